[rtl/core/sst_pkg.sv]
// Shared types, constants and helpers for the supercap supply state tracker.
// No dependencies; imported by every module of the block.
package sst_pkg;

  localparam int unsigned MV_W    = 16;
  localparam int unsigned TALLY_W = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned IDX_W   = 3;

  localparam logic [MV_W-1:0]    UNSET_MV  = 16'd10;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 8'hFF;

  // Result codes for supply_state
  localparam logic [CODE_W-1:0] ST_UNKNOWN  = 3'd0;
  localparam logic [CODE_W-1:0] ST_CHARGING = 3'd1;
  localparam logic [CODE_W-1:0] ST_STANDBY  = 3'd2;
  localparam logic [CODE_W-1:0] ST_ON_CAP   = 3'd3;
  localparam logic [CODE_W-1:0] ST_LOW      = 3'd4;
  localparam logic [CODE_W-1:0] ST_CRITICAL = 3'd5;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_FULL      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DROP_HYST = 3'd1;
  localparam logic [IDX_W-1:0] CFG_RECOVER   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_LOW       = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CRITICAL  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_CONFIRM   = 3'd5;

  typedef enum logic [5:0] {
    MODE_UNKNOWN  = 6'b000001,
    MODE_CHARGING = 6'b000010,
    MODE_STANDBY  = 6'b000100,
    MODE_ON_CAP   = 6'b001000,
    MODE_LOW      = 6'b010000,
    MODE_CRITICAL = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [MV_W-1:0]    full_mv;
    logic [MV_W-1:0]    drop_hysteresis_mv;
    logic [MV_W-1:0]    recover_margin_mv;
    logic [MV_W-1:0]    low_mv;
    logic [MV_W-1:0]    critical_mv;
    logic [TALLY_W-1:0] rise_confirm_count;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]    peak;
    logic [MV_W-1:0]    trough;
    mode_t              mode;
    logic [TALLY_W-1:0] tally;
  } trk_state_t;

  function automatic mode_t fresh_mode(logic [MV_W-1:0] level, logic [MV_W-1:0] full);
    return (level >= full) ? MODE_STANDBY : MODE_CHARGING;
  endfunction

  function automatic logic [CODE_W-1:0] mode_code(mode_t m);
    logic [CODE_W-1:0] code;
    case (m)
      MODE_UNKNOWN:  code = ST_UNKNOWN;
      MODE_CHARGING: code = ST_CHARGING;
      MODE_STANDBY:  code = ST_STANDBY;
      MODE_ON_CAP:   code = ST_ON_CAP;
      MODE_LOW:      code = ST_LOW;
      MODE_CRITICAL: code = ST_CRITICAL;
      default:       code = ST_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/sst_cfg_regs.sv]
// Configuration register bank of the supercap supply state tracker.
// Depends on sst_pkg for register indexes and the cfg_t bundle.
module sst_cfg_regs
  import sst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [MV_W-1:0]  wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_FULL:      cfg_nxt.full_mv            = wr_data;
        CFG_DROP_HYST: cfg_nxt.drop_hysteresis_mv = wr_data;
        CFG_RECOVER:   cfg_nxt.recover_margin_mv  = wr_data;
        CFG_LOW:       cfg_nxt.low_mv             = wr_data;
        CFG_CRITICAL:  cfg_nxt.critical_mv        = wr_data;
        CFG_CONFIRM:   cfg_nxt.rise_confirm_count = wr_data[TALLY_W-1:0];
        default:       cfg_nxt = cfg_r;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_mv            <= 16'd5000;
      cfg_r.drop_hysteresis_mv <= 16'd200;
      cfg_r.recover_margin_mv  <= 16'd300;
      cfg_r.low_mv             <= 16'd3500;
      cfg_r.critical_mv        <= 16'd3000;
      cfg_r.rise_confirm_count <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/sst_update.sv]
// Next-state logic of the supercap supply state tracker: one reading in,
// updated tracker state out. Purely combinational; depends on sst_pkg.
module sst_update
  import sst_pkg::*;
(
  input  logic [MV_W-1:0] voltage,
  input  cfg_t            cfg,
  input  trk_state_t      cur,
  output trk_state_t      nxt
);

  logic [MV_W-1:0]    peak_max;
  logic               drop_hit;
  logic [MV_W-1:0]    trough_upd;
  logic               recovering;
  logic [TALLY_W-1:0] tally_upd;
  logic               confirm;

  // Compare in 17 bits so neither the bound nor the sum can wrap
  assign peak_max   = (voltage > cur.peak) ? voltage : cur.peak;
  assign drop_hit   = ({1'b0, voltage} + {1'b0, cfg.drop_hysteresis_mv}) <= {1'b0, peak_max};
  assign trough_upd = ((cur.trough <= UNSET_MV) || (voltage < cur.trough)) ? voltage
                                                                             : cur.trough;
  assign recovering = {1'b0, voltage} >= ({1'b0, trough_upd} + {1'b0, cfg.recover_margin_mv});
  assign tally_upd  = !recovering ? '0 :
                      (cur.tally == TALLY_MAX) ? TALLY_MAX : cur.tally + 8'd1;
  assign confirm    = tally_upd >= cfg.rise_confirm_count;

  always_comb begin
    nxt = cur;
    if (cur.peak <= UNSET_MV) begin
      // first reading: restart tracking from this value
      nxt.peak   = voltage;
      nxt.trough = '0;
      nxt.mode   = fresh_mode(voltage, cfg.full_mv);
      nxt.tally  = '0;
    end else begin
      case (cur.mode)
        MODE_UNKNOWN, MODE_CHARGING, MODE_STANDBY: begin
          nxt.peak = peak_max;
          if (drop_hit) begin
            nxt.mode   = MODE_ON_CAP;
            nxt.trough = voltage;
            nxt.tally  = '0;
          end else begin
            nxt.mode = fresh_mode(peak_max, cfg.full_mv);
          end
        end
        default: begin
          if (confirm) begin
            nxt.peak   = voltage;
            nxt.trough = '0;
            nxt.mode   = fresh_mode(voltage, cfg.full_mv);
            nxt.tally  = '0;
          end else begin
            nxt.trough = trough_upd;
            nxt.tally  = tally_upd;
            if (voltage <= cfg.critical_mv) begin
              nxt.mode = MODE_CRITICAL;
            end else if (voltage <= cfg.low_mv) begin
              nxt.mode = MODE_LOW;
            end else begin
              nxt.mode = MODE_ON_CAP;
            end
          end
        end
      endcase
    end
  end

endmodule

[rtl/core/supercap_supply_state_tracker_core.sv]
// Top level of the supercap supply state tracker: input register, tracker
// state, output register. Uses sst_pkg, sst_cfg_regs and sst_update.
//
// Usage
//   Input channel (in_valid / in_stall / in_voltage_mv): one capacitor reading
//   in mV per transaction. Result channel (out_valid / out_stall / out_*):
//   one result per reading, in order, with the supply state code and the
//   tracked peak and trough after that reading.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   cfg_ready is always high; indexes 0..5 select full, drop hysteresis,
//   recover margin, low, critical and rise confirm count. Other indexes are
//   ignored. Write only while no reading is in flight.
//   Path: an accepted reading is held in the input register, then fires through the
//   update logic into the output register. Throughput: one reading per cycle while
//   the result side does not stall, set by the combinational tracker state update.
//   Reset (rst_n low, synchronous): both channels empty, peak, trough and
//   rise tally cleared, state unknown, registers back to their defaults.
//   Stall: while out_stall holds a waiting result, the input register still
//   takes one more reading; in_stall rises only once that register is full.
module supercap_supply_state_tracker_core
  import sst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // reading channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MV_W-1:0]   in_voltage_mv,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_supply_state,
  output logic [MV_W-1:0]   out_peak_out_mv,
  output logic [MV_W-1:0]   out_trough_out_mv,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [MV_W-1:0]   cfg_data
);

  cfg_t       cfg;
  trk_state_t state_r;
  trk_state_t state_nxt;

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [MV_W-1:0]   in_voltage_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CODE_W-1:0] out_state_r;
  logic [MV_W-1:0]   out_peak_r;
  logic [MV_W-1:0]   out_trough_r;

  logic advance;  // output register can take a new result this cycle
  logic load_in;  // reading transaction accepted
  logic fire;     // input register moves through the update logic

  assign cfg_ready = 1'b1;

  sst_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sst_update u_update (
    .voltage (in_voltage_r),
    .cfg     (cfg),
    .cur     (state_r),
    .nxt     (state_nxt)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;
  assign fire     = in_valid_r && advance;

  // Input register empties when its reading fires, refills on a new transaction
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (load_in) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Output register holds under stall, otherwise takes whatever fires
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r.peak   <= '0;
      state_r.trough <= '0;
      state_r.mode   <= MODE_UNKNOWN;
      state_r.tally  <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (load_in) begin
      in_voltage_r <= in_voltage_mv;
    end
    if (fire) begin
      out_state_r  <= mode_code(state_nxt.mode);
      out_peak_r   <= state_nxt.peak;
      out_trough_r <= state_nxt.trough;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_supply_state  = out_state_r;
  assign out_peak_out_mv   = out_peak_r;
  assign out_trough_out_mv = out_trough_r;

endmodule

[rtl/core/sst_checker.sv]
// Port-level checker for supercap_supply_state_tracker_core, bound to it below.
// Depends on sst_pkg for the state codes.
module sst_checker
  import sst_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CODE_W-1:0] out_supply_state,
  input logic [MV_W-1:0]   out_peak_out_mv,
  input logic [MV_W-1:0]   out_trough_out_mv
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_supply_state) && $stable(out_peak_out_mv)
                               && $stable(out_trough_out_mv))
    else $error("result payload changed while stalled");

  // Every reading settles on a real state: never unknown, never a spare code
  a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_supply_state != ST_UNKNOWN && out_supply_state <= ST_CRITICAL)
    else $error("result carries unknown or spare state code");

  // Outside the capacitor states the trough is unused and reads zero
  a_trough_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_supply_state == ST_CHARGING || out_supply_state == ST_STANDBY)
      |-> out_trough_out_mv == '0)
    else $error("trough nonzero while charging or on standby");

endmodule

bind supercap_supply_state_tracker_core sst_checker u_sst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_supply_state  (out_supply_state),
  .out_peak_out_mv   (out_peak_out_mv),
  .out_trough_out_mv (out_trough_out_mv)
);

[tb/sv/sst_result_checker.sv]
// Result checker for the supercap supply state tracker: follows the config port,
// predicts one report per accepted reading and compares the result channel.
// Depends on sst_pkg for widths, state codes, register indexes and cfg_t.
module sst_result_checker
  import sst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [MV_W-1:0]   in_voltage_mv,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CODE_W-1:0] out_supply_state,
  input  logic [MV_W-1:0]   out_peak_out_mv,
  input  logic [MV_W-1:0]   out_trough_out_mv,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [MV_W-1:0]   cfg_data,
  output int                fail_count,
  output int                pending_results,
  output int                results_checked,
  output int                mains_losses,
  output int                recoveries,
  output logic [7:0]        states_seen
);

  typedef struct packed {
    logic [CODE_W-1:0] supply_state;
    logic [MV_W-1:0]   peak_mv;
    logic [MV_W-1:0]   trough_mv;
  } supply_report_t;

  localparam cfg_t LIMITS_AT_RESET = '{
    full_mv:            16'd5000,
    drop_hysteresis_mv: 16'd200,
    recover_margin_mv:  16'd300,
    low_mv:             16'd3500,
    critical_mv:        16'd3000,
    rise_confirm_count: 8'd3
  };

  cfg_t               limits;
  logic [MV_W-1:0]    peak_mv;
  logic [MV_W-1:0]    trough_mv;
  logic [CODE_W-1:0]  state_code;
  logic [TALLY_W-1:0] rise_count;
  supply_report_t     expected_reports[$];
  supply_report_t     want;

  function automatic logic [CODE_W-1:0] entry_state(input logic [MV_W-1:0] level);
    return (level >= limits.full_mv) ? ST_STANDBY : ST_CHARGING;
  endfunction

  // Advance the tracker by one reading and return the report it produces.
  function automatic supply_report_t track_reading(input logic [MV_W-1:0] mv);
    int   mv_i;
    int   peak_i;
    int   trough_i;
    int   hyst_i;
    int   margin_i;
    logic recovering;
    mv_i     = int'(mv);
    hyst_i   = int'(limits.drop_hysteresis_mv);
    margin_i = int'(limits.recover_margin_mv);
    if (peak_mv <= UNSET_MV) begin
      peak_mv    = mv;
      trough_mv  = '0;
      state_code = entry_state(mv);
      rise_count = '0;
    end else if (state_code == ST_UNKNOWN || state_code == ST_CHARGING ||
                 state_code == ST_STANDBY) begin
      if (mv > peak_mv) peak_mv = mv;
      peak_i = int'(peak_mv);
      if (mv_i <= peak_i - hyst_i) begin
        state_code = ST_ON_CAP;
        trough_mv  = mv;
        rise_count = '0;
        mains_losses++;
      end else begin
        state_code = entry_state(peak_mv);
      end
    end else begin
      if (trough_mv <= UNSET_MV || mv < trough_mv) trough_mv = mv;
      trough_i   = int'(trough_mv);
      recovering = (mv_i >= trough_i + margin_i);
      if (!recovering) begin
        rise_count = '0;
      end else if (rise_count != TALLY_MAX) begin
        rise_count++;
      end
      if (rise_count >= limits.rise_confirm_count) begin
        peak_mv    = mv;
        trough_mv  = '0;
        state_code = entry_state(mv);
        rise_count = '0;
        recoveries++;
      end else if (mv <= limits.critical_mv) begin
        state_code = ST_CRITICAL;
      end else if (mv <= limits.low_mv) begin
        state_code = ST_LOW;
      end else begin
        state_code = ST_ON_CAP;
      end
    end
    return '{state_code, peak_mv, trough_mv};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      limits     = LIMITS_AT_RESET;
      peak_mv    = '0;
      trough_mv  = '0;
      state_code = ST_UNKNOWN;
      rise_count = '0;
      states_seen = '0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FULL:      limits.full_mv            = cfg_data;
          CFG_DROP_HYST: limits.drop_hysteresis_mv = cfg_data;
          CFG_RECOVER:   limits.recover_margin_mv  = cfg_data;
          CFG_LOW:       limits.low_mv             = cfg_data;
          CFG_CRITICAL:  limits.critical_mv        = cfg_data;
          CFG_CONFIRM:   limits.rise_confirm_count = cfg_data[TALLY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_reports.push_back(track_reading(in_voltage_mv));
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: supply_state %0d peak_out_mv %0d trough_out_mv %0d",
                 out_supply_state, out_peak_out_mv, out_trough_out_mv);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          results_checked++;
          states_seen[want.supply_state] = 1'b1;
          if (out_supply_state !== want.supply_state) begin
            $error("supply_state: expected %0d, actual %0d", want.supply_state, out_supply_state);
            fail_count++;
          end
          if (out_peak_out_mv !== want.peak_mv) begin
            $error("peak_out_mv: expected %0d, actual %0d", want.peak_mv, out_peak_out_mv);
            fail_count++;
          end
          if (out_trough_out_mv !== want.trough_mv) begin
            $error("trough_out_mv: expected %0d, actual %0d", want.trough_mv, out_trough_out_mv);
            fail_count++;
          end
        end
      end
    end
    pending_results <= expected_reports.size();
  end

endmodule

[tb/sv/supercap_supply_state_tracker_core_test.sv]
// Top of the supply state tracker testbench: clock, reset, readings, config
// writes, result-side stalls and the verdict. Depends on sst_pkg, the core
// supercap_supply_state_tracker_core and the checker sst_result_checker.
module supercap_supply_state_tracker_core_test;
  import sst_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int MAX_WAIT     = 18;
  localparam int HOLD_CYCLES  = 160;     // long result-side hold-off to back up the core
  localparam int DRAIN_SLACK  = 8;       // extra wait after the result channel has drained
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MV_TOP       = 2**MV_W - 1;

  // Indexes past the last register; the core must ignore writes to them.
  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [MV_W-1:0]   in_voltage_mv;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] out_supply_state;
  logic [MV_W-1:0]   out_peak_out_mv;
  logic [MV_W-1:0]   out_trough_out_mv;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [MV_W-1:0]   cfg_data;

  int         fail_count;
  int         pending_results;
  int         results_checked;
  int         mains_losses;
  int         recoveries;
  logic [7:0] states_seen;

  cfg_t setting;              // stimulus copy of the thresholds, used to aim readings
  int   readings_sent = 0;
  int   send_calm     = 0;
  int   recv_calm     = 0;
  int   stall_left    = 0;
  logic pressure_go   = 1'b0;
  logic hold_off      = 1'b0;

  // Opening sequence under reset thresholds: first-reading detection, standby
  // and charging, the exact hysteresis drop, low and critical boundaries, the
  // unset trough replaced by a small reading, a recovery broken by a dip and
  // a confirmed recovery.
  logic [MV_W-1:0] opening_readings [0:24] = '{
    16'd0, 16'd10, 16'd4800, 16'd4999, 16'd5000, 16'd65535, 16'd65336, 16'd65335,
    16'd3501, 16'd3500, 16'd3001, 16'd3000, 16'd0, 16'd5, 16'd304, 16'd305,
    16'd3600, 16'd300, 16'd4000, 16'd4000, 16'd6000, 16'd5800, 16'd6100, 16'd9,
    16'd7
  };

  always #HALF_PERIOD clk = ~clk;

  supercap_supply_state_tracker_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_voltage_mv     (in_voltage_mv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_supply_state  (out_supply_state),
    .out_peak_out_mv   (out_peak_out_mv),
    .out_trough_out_mv (out_trough_out_mv),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  sst_result_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_voltage_mv     (in_voltage_mv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_supply_state  (out_supply_state),
    .out_peak_out_mv   (out_peak_out_mv),
    .out_trough_out_mv (out_trough_out_mv),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked),
    .mains_losses      (mains_losses),
    .recoveries        (recoveries),
    .states_seen       (states_seen)
  );

  // Draw the wait before the next transaction; now and then run a stretch
  // of back-to-back transactions with no wait at all.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [MV_W-1:0] clamp_mv(input int mv);
    if (mv < 0) return '0;
    if (mv > MV_TOP) return '1;
    return mv[MV_W-1:0];
  endfunction

  function automatic cfg_t make_setting(input int full_v, input int hyst_v, input int margin_v,
                                        input int low_v, input int crit_v, input int confirm_v);
    cfg_t c;
    c.full_mv            = MV_W'(full_v);
    c.drop_hysteresis_mv = MV_W'(hyst_v);
    c.recover_margin_mv  = MV_W'(margin_v);
    c.low_mv             = MV_W'(low_v);
    c.critical_mv        = MV_W'(crit_v);
    c.rise_confirm_count = TALLY_W'(confirm_v);
    return c;
  endfunction

  // Result side: after each accepted result hold stall for a drawn number of
  // cycles; the hold-off process can force it high on top of that.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = draw_wait(recv_calm);
      out_stall <= hold_off || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Hold the result side off once, long enough for the core to fill and
  // raise in_stall while readings keep coming.
  initial begin
    do @(posedge clk); while (!pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stop a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one reading after a drawn gap and hold it until the core takes it.
  task automatic send_reading(input logic [MV_W-1:0] mv);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_voltage_mv <= mv;
    do @(posedge clk); while (in_stall);
    readings_sent++;
  endtask

  // Drop valid and wait until every report has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register back to back; call only with nothing in flight.
  task automatic apply_setting(input cfg_t c, input bit poke_spare);
    setting = c;
    write_reg(CFG_FULL,      c.full_mv);
    write_reg(CFG_DROP_HYST, c.drop_hysteresis_mv);
    write_reg(CFG_RECOVER,   c.recover_margin_mv);
    write_reg(CFG_LOW,       c.low_mv);
    write_reg(CFG_CRITICAL,  c.critical_mv);
    write_reg(CFG_CONFIRM,   {{(MV_W-TALLY_W){1'b0}}, c.rise_confirm_count});
    if (poke_spare) begin
      write_reg(CFG_SPARE_LO, MV_W'($urandom_range(0, MV_TOP)));
      write_reg(CFG_SPARE_HI, MV_W'($urandom_range(0, MV_TOP)));
    end
    cfg_valid <= 1'b0;
  endtask

  // One mains cycle: charge up toward full, lose mains by at least the
  // hysteresis, sag through the low and critical bands, then climb back
  // with the confirm count of recovering readings (sometimes broken by a dip).
  task automatic mains_cycle();
    int n;
    int top;
    int cur;
    int low_point;
    int margin_i;
    int low_i;
    int crit_i;
    margin_i = int'(setting.recover_margin_mv);
    low_i    = int'(setting.low_mv);
    crit_i   = int'(setting.critical_mv);
    top = int'(setting.full_mv) - 600 + $urandom_range(0, 1200);
    if (top <= int'(UNSET_MV)) top = int'(UNSET_MV) + 1 + $urandom_range(0, 500);
    n = $urandom_range(1, 6);
    for (int k = n - 1; k >= 0; k--) send_reading(clamp_mv(top - k * $urandom_range(0, 60)));
    cur = int'(clamp_mv(top - int'(setting.drop_hysteresis_mv) - $urandom_range(0, 150)));
    send_reading(clamp_mv(cur));
    low_point = cur;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0:       cur = cur - $urandom_range(0, 300);
        1:       cur = low_i + $urandom_range(0, 2) - 1;
        2:       cur = crit_i + $urandom_range(0, 2) - 1;
        default: cur = $urandom_range(0, low_i + 400);
      endcase
      cur = int'(clamp_mv(cur));
      send_reading(clamp_mv(cur));
      if (cur < low_point) low_point = cur;
    end
    for (int k = 0; k < int'(setting.rise_confirm_count); k++) begin
      if (setting.rise_confirm_count <= 16 && $urandom_range(0, 7) == 0) begin
        send_reading(clamp_mv(low_point + $urandom_range(0, margin_i)));
      end else begin
        send_reading(clamp_mv(low_point + margin_i + $urandom_range(0, 400)));
      end
    end
  endtask

  // Short burst of unrelated readings: anything in range, first-reading
  // sized values, threshold neighbors and the ends of the range.
  task automatic noise_burst();
    int n;
    int pick;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0, 3: send_reading(MV_W'($urandom_range(0, MV_TOP)));
        1:    send_reading(MV_W'($urandom_range(0, int'(UNSET_MV) + 1)));
        2: begin
          case ($urandom_range(0, 4))
            0:       pick = int'(setting.full_mv);
            1:       pick = int'(setting.low_mv);
            2:       pick = int'(setting.critical_mv);
            3:       pick = int'(setting.drop_hysteresis_mv);
            default: pick = int'(setting.recover_margin_mv);
          endcase
          send_reading(clamp_mv(pick + $urandom_range(0, 2) - 1));
        end
        default: send_reading($urandom_range(0, 1) ? '1 : '0);
      endcase
    end
  endtask

  // Mostly well-formed mains cycles, the rest noise.
  task automatic run_random(input int budget);
    int stop_at;
    stop_at = readings_sent + budget;
    while (readings_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) mains_cycle();
      else noise_burst();
    end
  endtask

  initial begin
    int low_pick;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_voltage_mv <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_FULL;
    cfg_data      <= '0;
    setting = make_setting(5000, 200, 300, 3500, 3000, 3);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_readings[i]) send_reading(opening_readings[i]);

    // Random traffic under reset thresholds, with the long hold-off.
    pressure_go <= 1'b1;
    run_random(80);

    // Every threshold at its floor, then at its ceiling.
    drain_results();
    apply_setting(make_setting(0, 0, 0, 0, 0, 1), 1'b0);
    run_random(50);
    drain_results();
    apply_setting(make_setting(MV_TOP, MV_TOP, MV_TOP, MV_TOP, MV_TOP, 255), 1'b0);
    run_random(60);

    // Random thresholds in a useful band.
    for (int p = 0; p < 2; p++) begin
      drain_results();
      low_pick = $urandom_range(1000, 6000);
      apply_setting(make_setting($urandom_range(1000, 9000), $urandom_range(0, 1500),
                                 $urandom_range(0, 1500), low_pick,
                                 $urandom_range(500, low_pick), $urandom_range(1, 6)),
                    p == 0);
      run_random(30);
    end

    // Longest confirm count: one full recovery takes 255 recovering readings.
    drain_results();
    apply_setting(make_setting(5000, 200, 300, 3500, 3000, 255), 1'b0);
    run_random(60);

    // Quick recovery with wide random thresholds.
    drain_results();
    apply_setting(make_setting($urandom_range(0, MV_TOP), $urandom_range(0, MV_TOP),
                               $urandom_range(0, 4000), $urandom_range(0, MV_TOP),
                               $urandom_range(0, MV_TOP), $urandom_range(1, 2)), 1'b1);
    run_random(40);

    drain_results();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Run covered %0d readings and %0d checked results, %0d mains losses, %0d recoveries.",
             readings_sent, results_checked, mains_losses, recoveries);
    $display("Supply state codes reached (bit per code): %b", states_seen[5:0]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/sst_pkg.sv
rtl/core/sst_cfg_regs.sv
rtl/core/sst_update.sv
rtl/core/supercap_supply_state_tracker_core.sv
rtl/core/sst_checker.sv
tb/sv/sst_result_checker.sv
tb/sv/supercap_supply_state_tracker_core_test.sv
